// File: src/closest_point_on_triangle_assert.svh
// Assertion macros for the closest point pipeline.
`ifndef CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
// same-cycle implication, clocked on clock, off during reset
`define CPOT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cpot check failed");
// next-cycle implication
`define CPOT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cpot check failed");
`endif

// File: src/cpot_pkg.sv
`default_nettype none
package cpot_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 2;
   localparam int HW = (SW + 1) / 2;
   localparam int VW = 2 * SW + 1;
   localparam int NW = VW + 2;

   localparam logic [2:0] REG_A        = 3'd0;
   localparam logic [2:0] REG_B        = 3'd1;
   localparam logic [2:0] REG_C        = 3'd2;
   localparam logic [2:0] REG_AB       = 3'd3;
   localparam logic [2:0] REG_AC       = 3'd4;
   localparam logic [2:0] REG_BC       = 3'd5;
   localparam logic [2:0] REG_INTERIOR = 3'd6;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] px;
      logic signed [COORD_WIDTH-1:0] py;
      logic signed [COORD_WIDTH-1:0] pz;
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] az;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by_coord;
      logic signed [COORD_WIDTH-1:0] bz;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] cz;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] qx;
      logic signed [COORD_WIDTH-1:0] qy;
      logic signed [COORD_WIDTH-1:0] qz;
      logic        [2:0]             region;
   } rsp_type;

   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] a;
      logic [2:0][COORD_WIDTH-1:0] b;
      logic [2:0][COORD_WIDTH-1:0] c;
      logic [2:0][DW-1:0]          ab;
      logic [2:0][DW-1:0]          ac;
      logic [2:0][DW-1:0]          bc;
   } geo_type;

   typedef struct packed {
      logic [2:0]                  region;
      logic [2:0][COORD_WIDTH-1:0] base;
      logic [2:0][DW-1:0]          e1;
      logic [2:0][DW-1:0]          e2;
   } ctx_type;
endpackage
`default_nettype wire

// File: src/closest_point_on_triangle.sv
// Closest point on a triangle to a query point, signed fixed point.
// Request: a word (point p, vertices a, b, c) is taken at a clock edge with
// start high and busy low. busy is high only during reset, so a new word may
// enter on every cycle.
// Response: rsp_valid is high for one cycle with rsp_word holding the closest
// point (saturated) and the region code: vertex a, b, c, edge ab, ac, bc or
// interior.
// Throughput: one word per cycle. The weight dividers resolve one quotient bit
// per stage, after nine stages of differences, dot products, wide products
// split into half-width partial products, and region selection.
// Reset clears every valid bit; words in flight are dropped.
// The receiver cannot stall: each result appears once, on its one cycle.
`default_nettype none
module closest_point_on_triangle #(
   parameter int FRAC_BITS = cpot_pkg::FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cpot_pkg::req_type req_word,
   output logic                   rsp_valid,
   output cpot_pkg::rsp_type      rsp_word
);
   localparam int CW  = cpot_pkg::COORD_WIDTH;
   localparam int DW  = cpot_pkg::DW;
   localparam int PW  = cpot_pkg::PW;
   localparam int SW  = cpot_pkg::SW;
   localparam int HW  = cpot_pkg::HW;
   localparam int VW  = cpot_pkg::VW;
   localparam int NW  = cpot_pkg::NW;
   localparam int MW  = 2 * SW;
   localparam int PPW = 2 * HW;
   localparam int WW  = FRAC_BITS + 1;
   localparam int TW  = DW + WW + 1;
   localparam int XW  = TW + 3;
   localparam int NST = FRAC_BITS + 12;
   localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
   localparam int MB [6] = '{3, 1, 1, 5, 5, 3};
   localparam logic [WW-1:0] W_ONE = WW'(1) << FRAC_BITS;
   localparam logic signed [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);
   localparam logic signed [XW-1:0] MAXC = XW'({(CW - 1){1'b1}});
   localparam logic signed [XW-1:0] MINC = ~MAXC;

   logic                    accept;
   logic [NST-1:0]          vld_ff;

   cpot_pkg::geo_type       geo_in;
   cpot_pkg::geo_type       geo_ff [7];
   logic [2:0][DW-1:0]      s1_dp_in [3];
   logic [2:0][DW-1:0]      s1_dp_ff [3];

   logic signed [PW-1:0]    s2_pr_in [6][3];
   logic signed [PW-1:0]    s2_pr_ff [6][3];
   logic signed [SW-1:0]    s3_d_ff  [6];
   logic signed [SW-1:0]    dq_ff    [4][6];
   logic [SW-1:0]           s4_mag_ff [6];
   logic                    s4_neg_ff [6];
   logic [PPW-1:0]          s5_pp_ff [6][4];
   logic                    s5_neg_ff [6];
   logic signed [VW-1:0]    s6_p_ff  [6];
   logic signed [VW-1:0]    s7_v_ff  [3];

   cpot_pkg::ctx_type       s8_ctx_in, s8_ctx_ff;
   logic signed [NW-1:0]    s8_n_in [2], s8_n_ff [2];
   logic signed [NW-1:0]    s8_den_in, s8_den_ff;
   cpot_pkg::ctx_type       s9_ctx_ff;
   logic [NW-1:0]           s9_mn_ff [2], s9_md_ff [2];
   logic                    s9_z_ff  [2];

   cpot_pkg::ctx_type       dv_ctx_ff [FRAC_BITS+1];
   logic [NW:0]             dv_r_ff   [FRAC_BITS+1][2];
   logic [NW-1:0]           dv_d_ff   [FRAC_BITS+1][2];
   logic [FRAC_BITS-1:0]    dv_q_ff   [FRAC_BITS+1][2];
   logic                    dv_z_ff   [FRAC_BITS+1][2];
   logic                    dv_o_ff   [FRAC_BITS+1][2];

   logic [WW-1:0]           w_in [2];
   cpot_pkg::ctx_type       sm_ctx_ff;
   logic signed [TW-1:0]    sm_t1_ff [3], sm_t2_ff [3];
   cpot_pkg::rsp_type       rsp_in, rsp_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NST-2:0], accept};
      end
   end

   // differences
   always_comb begin
      logic [2:0][CW-1:0] p;
      p = {req_word.pz, req_word.py, req_word.px};
      geo_in.a = {req_word.az, req_word.ay, req_word.ax};
      geo_in.b = {req_word.bz, req_word.by_coord, req_word.bx};
      geo_in.c = {req_word.cz, req_word.cy, req_word.cx};
      for (int k = 0; k < 3; k++) begin
         geo_in.ab[k] = DW'($signed(geo_in.b[k])) - DW'($signed(geo_in.a[k]));
         geo_in.ac[k] = DW'($signed(geo_in.c[k])) - DW'($signed(geo_in.a[k]));
         geo_in.bc[k] = DW'($signed(geo_in.c[k])) - DW'($signed(geo_in.b[k]));
         s1_dp_in[0][k] = DW'($signed(p[k])) - DW'($signed(geo_in.a[k]));
         s1_dp_in[1][k] = DW'($signed(p[k])) - DW'($signed(geo_in.b[k]));
         s1_dp_in[2][k] = DW'($signed(p[k])) - DW'($signed(geo_in.c[k]));
      end
   end

   // dot product terms
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         for (int k = 0; k < 3; k++) begin
            s2_pr_in[i][k] = $signed((i % 2 == 0) ? geo_ff[0].ab[k] : geo_ff[0].ac[k])
                           * $signed(s1_dp_ff[i / 2][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      geo_ff[0] <= geo_in;
      for (int j = 1; j < 7; j++) begin
         geo_ff[j] <= geo_ff[j-1];
      end
      s1_dp_ff <= s1_dp_in;
      s2_pr_ff <= s2_pr_in;
      for (int i = 0; i < 6; i++) begin
         s3_d_ff[i] <= SW'(s2_pr_ff[i][0]) + SW'(s2_pr_ff[i][1]) + SW'(s2_pr_ff[i][2]);
         dq_ff[0][i] <= s3_d_ff[i];
         s4_neg_ff[i] <= s3_d_ff[i][SW-1];
         s4_mag_ff[i] <= s3_d_ff[i][SW-1] ? SW'(-s3_d_ff[i]) : SW'(s3_d_ff[i]);
         for (int j = 1; j < 4; j++) begin
            dq_ff[j][i] <= dq_ff[j-1][i];
         end
      end
      // split the wide products into half-width partial products
      for (int j = 0; j < 6; j++) begin
         s5_neg_ff[j] <= s4_neg_ff[MA[j]] ^ s4_neg_ff[MB[j]];
         s5_pp_ff[j][0] <= s4_mag_ff[MA[j]][HW-1:0] * s4_mag_ff[MB[j]][HW-1:0];
         s5_pp_ff[j][1] <= s4_mag_ff[MA[j]][HW-1:0] * s4_mag_ff[MB[j]][SW-1:HW];
         s5_pp_ff[j][2] <= s4_mag_ff[MA[j]][SW-1:HW] * s4_mag_ff[MB[j]][HW-1:0];
         s5_pp_ff[j][3] <= s4_mag_ff[MA[j]][SW-1:HW] * s4_mag_ff[MB[j]][SW-1:HW];
      end
      for (int j = 0; j < 6; j++) begin
         s6_p_ff[j] <= s5_neg_ff[j]
            ? -VW'(MW'(s5_pp_ff[j][0]) + (MW'(s5_pp_ff[j][1]) << HW)
                  + (MW'(s5_pp_ff[j][2]) << HW) + (MW'(s5_pp_ff[j][3]) << (2 * HW)))
            : VW'(MW'(s5_pp_ff[j][0]) + (MW'(s5_pp_ff[j][1]) << HW)
                  + (MW'(s5_pp_ff[j][2]) << HW) + (MW'(s5_pp_ff[j][3]) << (2 * HW)));
      end
      for (int j = 0; j < 3; j++) begin
         s7_v_ff[j] <= s6_p_ff[2*j] - s6_p_ff[2*j+1];
      end
   end

   // region selection
   always_comb begin
      logic signed [SW:0] e43, e56, d13, d26;
      e43 = (SW+1)'(dq_ff[3][3]) - (SW+1)'(dq_ff[3][2]);
      e56 = (SW+1)'(dq_ff[3][4]) - (SW+1)'(dq_ff[3][5]);
      d13 = (SW+1)'(dq_ff[3][0]) - (SW+1)'(dq_ff[3][2]);
      d26 = (SW+1)'(dq_ff[3][1]) - (SW+1)'(dq_ff[3][5]);
      s8_ctx_in.base = geo_ff[6].a;
      s8_ctx_in.e1   = geo_ff[6].ab;
      s8_ctx_in.e2   = geo_ff[6].ac;
      s8_n_in[0] = '0;
      s8_n_in[1] = '0;
      s8_den_in  = '0;
      if (dq_ff[3][0] <= 0 && dq_ff[3][1] <= 0) begin
         s8_ctx_in.region = cpot_pkg::REG_A;
      end else if (dq_ff[3][2] >= 0 && e43 <= 0) begin
         s8_ctx_in.region = cpot_pkg::REG_B;
         s8_ctx_in.base   = geo_ff[6].b;
      end else if (dq_ff[3][5] >= 0 && e56 <= 0) begin
         s8_ctx_in.region = cpot_pkg::REG_C;
         s8_ctx_in.base   = geo_ff[6].c;
      end else if (s7_v_ff[0] <= 0 && dq_ff[3][0] >= 0 && dq_ff[3][2] <= 0) begin
         s8_ctx_in.region = cpot_pkg::REG_AB;
         s8_n_in[0] = NW'(dq_ff[3][0]);
         s8_den_in  = NW'(d13);
      end else if (s7_v_ff[1] <= 0 && dq_ff[3][1] >= 0 && dq_ff[3][5] <= 0) begin
         s8_ctx_in.region = cpot_pkg::REG_AC;
         s8_ctx_in.e1 = geo_ff[6].ac;
         s8_n_in[0] = NW'(dq_ff[3][1]);
         s8_den_in  = NW'(d26);
      end else if (s7_v_ff[2] <= 0 && e43 >= 0 && e56 >= 0) begin
         s8_ctx_in.region = cpot_pkg::REG_BC;
         s8_ctx_in.base = geo_ff[6].b;
         s8_ctx_in.e1   = geo_ff[6].bc;
         s8_n_in[0] = NW'(e43);
         s8_den_in  = NW'(e43) + NW'(e56);
      end else begin
         s8_ctx_in.region = cpot_pkg::REG_INTERIOR;
         s8_n_in[0] = NW'(s7_v_ff[1]);
         s8_n_in[1] = NW'(s7_v_ff[0]);
         s8_den_in  = NW'(s7_v_ff[0]) + NW'(s7_v_ff[1]) + NW'(s7_v_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      s8_ctx_ff <= s8_ctx_in;
      s8_n_ff   <= s8_n_in;
      s8_den_ff <= s8_den_in;
      s9_ctx_ff <= s8_ctx_ff;
      dv_ctx_ff[0] <= s9_ctx_ff;
      for (int l = 0; l < 2; l++) begin
         s9_z_ff[l]  <= (s8_den_ff == '0) || (s8_n_ff[l] == '0)
                        || (s8_n_ff[l][NW-1] != s8_den_ff[NW-1]);
         s9_mn_ff[l] <= s8_n_ff[l][NW-1] ? NW'(-s8_n_ff[l]) : NW'(s8_n_ff[l]);
         s9_md_ff[l] <= s8_den_ff[NW-1] ? NW'(-s8_den_ff) : NW'(s8_den_ff);
         dv_r_ff[0][l] <= {1'b0, s9_mn_ff[l]};
         dv_d_ff[0][l] <= s9_md_ff[l];
         dv_q_ff[0][l] <= '0;
         dv_z_ff[0][l] <= s9_z_ff[l];
         dv_o_ff[0][l] <= s9_mn_ff[l] >= s9_md_ff[l];
      end
      // one quotient bit per stage
      for (int j = 1; j <= FRAC_BITS; j++) begin
         dv_ctx_ff[j] <= dv_ctx_ff[j-1];
         for (int l = 0; l < 2; l++) begin
            dv_d_ff[j][l] <= dv_d_ff[j-1][l];
            dv_z_ff[j][l] <= dv_z_ff[j-1][l];
            dv_o_ff[j][l] <= dv_o_ff[j-1][l];
            if ({dv_r_ff[j-1][l][NW-1:0], 1'b0} >= {1'b0, dv_d_ff[j-1][l]}) begin
               dv_r_ff[j][l] <= {dv_r_ff[j-1][l][NW-1:0], 1'b0} - {1'b0, dv_d_ff[j-1][l]};
               dv_q_ff[j][l] <= {dv_q_ff[j-1][l][FRAC_BITS-2:0], 1'b1};
            end else begin
               dv_r_ff[j][l] <= {dv_r_ff[j-1][l][NW-1:0], 1'b0};
               dv_q_ff[j][l] <= {dv_q_ff[j-1][l][FRAC_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (dv_z_ff[FRAC_BITS][l]) begin
            w_in[l] = '0;
         end else if (dv_o_ff[FRAC_BITS][l]) begin
            w_in[l] = W_ONE;
         end else begin
            w_in[l] = {1'b0, dv_q_ff[FRAC_BITS][l]};
         end
      end
   end

   // round, add base, saturate
   always_comb begin
      logic signed [XW-1:0] acc;
      logic signed [CW-1:0] q [3];
      for (int k = 0; k < 3; k++) begin
         acc = XW'(sm_t1_ff[k]) + XW'(sm_t2_ff[k]) + HALF;
         acc = (acc >>> FRAC_BITS) + XW'($signed(sm_ctx_ff.base[k]));
         if (acc > MAXC) begin
            q[k] = MAXC[CW-1:0];
         end else if (acc < MINC) begin
            q[k] = MINC[CW-1:0];
         end else begin
            q[k] = acc[CW-1:0];
         end
      end
      rsp_in.qx = q[0];
      rsp_in.qy = q[1];
      rsp_in.qz = q[2];
      rsp_in.region = sm_ctx_ff.region;
   end

   always_ff @(posedge clock) begin
      sm_ctx_ff <= dv_ctx_ff[FRAC_BITS];
      for (int k = 0; k < 3; k++) begin
         sm_t1_ff[k] <= $signed({1'b0, w_in[0]}) * $signed(dv_ctx_ff[FRAC_BITS].e1[k]);
         sm_t2_ff[k] <= $signed({1'b0, w_in[1]}) * $signed(dv_ctx_ff[FRAC_BITS].e2[k]);
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[NST-1];
   assign rsp_word  = rsp_ff;

`include "closest_point_on_triangle_assert.svh"
   `CPOT_ASSERT_NOW(a_latency, rsp_valid, $past(accept, NST))
   `CPOT_ASSERT_NOW(a_vertex_a, rsp_valid && rsp_word.region == cpot_pkg::REG_A,
      rsp_word.qx == $past(req_word.ax, NST))
   `CPOT_ASSERT_NOW(a_second_weight, vld_ff[FRAC_BITS+9]
      && dv_ctx_ff[FRAC_BITS].region != cpot_pkg::REG_INTERIOR, w_in[1] == '0)
   `CPOT_ASSERT_NEXT(a_vertex_no_weight, vld_ff[FRAC_BITS+9]
      && dv_ctx_ff[FRAC_BITS].region == cpot_pkg::REG_B, sm_t1_ff[0] == '0)

endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cpot_pkg::*;

   typedef logic signed [255:0] wide_t;
   typedef struct {
      req_type word;
      bit      known;
      rsp_type result;
   } row_type;

   localparam int ONE = 1 << FRAC_BITS;
   localparam logic signed [31:0] MAXC = 32'sh7fffffff;
   localparam logic signed [31:0] MINC = 32'sh80000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_valid;
   rsp_type rsp_word;

   rsp_type pending[$];
   int      errors = 0;
   int      sender_idle = 0;

   closest_point_on_triangle dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report(input string what);
      $display("mismatch %s", what);
      errors++;
   endtask

   function automatic wide_t frac_weight(input wide_t num, input wide_t den);
      wide_t q;
      if (den == 0 || num == 0 || (num < 0) != (den < 0)) return 0;
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      q = (num <<< FRAC_BITS) / den;
      if (q > ONE) q = ONE;
      return q;
   endfunction

   function automatic logic [31:0] round_sat(input wide_t base, input wide_t sum);
      wide_t v;
      v = ((sum + (ONE >>> 1)) >>> FRAC_BITS) + base;
      if (v > wide_t'(MAXC)) return MAXC;
      if (v < wide_t'(MINC)) return MINC;
      return v[31:0];
   endfunction

   function automatic rsp_type closest_point(input req_type r);
      wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
      wide_t base[3], sum[3];
      wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, v, w, den;
      rsp_type o;
      p = '{r.px, r.py, r.pz};
      a = '{r.ax, r.ay, r.az};
      b = '{r.bx, r.by_coord, r.bz};
      c = '{r.cx, r.cy, r.cz};
      for (int k = 0; k < 3; k++) begin
         ab[k] = b[k] - a[k]; ac[k] = c[k] - a[k]; bc[k] = c[k] - b[k];
         ap[k] = p[k] - a[k]; bp[k] = p[k] - b[k]; cp[k] = p[k] - c[k];
         sum[k] = 0; base[k] = a[k];
      end
      d1 = ab[0]*ap[0] + ab[1]*ap[1] + ab[2]*ap[2];
      d2 = ac[0]*ap[0] + ac[1]*ap[1] + ac[2]*ap[2];
      d3 = ab[0]*bp[0] + ab[1]*bp[1] + ab[2]*bp[2];
      d4 = ac[0]*bp[0] + ac[1]*bp[1] + ac[2]*bp[2];
      d5 = ab[0]*cp[0] + ab[1]*cp[1] + ab[2]*cp[2];
      d6 = ac[0]*cp[0] + ac[1]*cp[1] + ac[2]*cp[2];
      vc = d1*d4 - d3*d2;
      vb = d5*d2 - d1*d6;
      va = d3*d6 - d5*d4;
      if (d1 <= 0 && d2 <= 0) begin
         o.region = REG_A;
      end else if (d3 >= 0 && d4 - d3 <= 0) begin
         o.region = REG_B; base = b;
      end else if (d6 >= 0 && d5 - d6 <= 0) begin
         o.region = REG_C; base = c;
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
         o.region = REG_AB;
         v = frac_weight(d1, d1 - d3);
         for (int k = 0; k < 3; k++) sum[k] = v * ab[k];
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
         o.region = REG_AC;
         w = frac_weight(d2, d2 - d6);
         for (int k = 0; k < 3; k++) sum[k] = w * ac[k];
      end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
         o.region = REG_BC; base = b;
         w = frac_weight(d4 - d3, (d4 - d3) + (d5 - d6));
         for (int k = 0; k < 3; k++) sum[k] = w * bc[k];
      end else begin
         o.region = REG_INTERIOR;
         den = va + vb + vc;
         v = frac_weight(vb, den);
         w = frac_weight(vc, den);
         for (int k = 0; k < 3; k++) sum[k] = v * ab[k] + w * ac[k];
      end
      o.qx = round_sat(base[0], sum[0]);
      o.qy = round_sat(base[1], sum[1]);
      o.qz = round_sat(base[2], sum[2]);
      return o;
   endfunction

   function automatic req_type make_word(input int p0, p1, p2, a0, a1, a2,
                                         input int b0, b1, b2, c0, c1, c2);
      return '{p0, p1, p2, a0, a1, a2, b0, b1, b2, c0, c1, c2};
   endfunction

   function automatic logic [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return ($urandom_range(2) == 0) ? MAXC : MINC;
         default: return $signed($urandom_range(16 * ONE)) - 8 * ONE;
      endcase
   endfunction

   function automatic req_type rand_word();
      req_type r;
      int mode;
      mode = ($urandom_range(9) < 3) ? 0 : 2;
      r.px = rand_coord(mode); r.py = rand_coord(mode); r.pz = rand_coord(mode);
      r.ax = rand_coord(mode); r.ay = rand_coord(mode); r.az = rand_coord(mode);
      r.bx = rand_coord(mode); r.by_coord = rand_coord(mode); r.bz = rand_coord(mode);
      r.cx = rand_coord(mode); r.cy = rand_coord(mode); r.cz = rand_coord(mode);
      if ($urandom_range(19) == 0) r.px = rand_coord(1);
      if ($urandom_range(19) == 0) r.bz = rand_coord(1);
      case ($urandom_range(19))
         0: begin r.bx = r.ax; r.by_coord = r.ay; r.bz = r.az; end
         1: begin r.cx = r.ax; r.cy = r.ay; r.cz = r.az; end
         2: begin r.cx = r.bx; r.cy = r.by_coord; r.cz = r.bz; end
         3: begin r.az = 0; r.bz = 0; r.cz = 0; end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send(input req_type w);
      while ($urandom_range(99) < sender_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && start && !busy) pending.push_back(closest_point(req_word));
      if (!reset && rsp_valid) begin
         if (pending.size() == 0) begin
            report($sformatf("unexpected word %h", rsp_word));
         end else begin
            rsp_type want;
            want = pending.pop_front();
            if (rsp_word.qx !== want.qx)
               report($sformatf("qx: got %h want %h", rsp_word.qx, want.qx));
            if (rsp_word.qy !== want.qy)
               report($sformatf("qy: got %h want %h", rsp_word.qy, want.qy));
            if (rsp_word.qz !== want.qz)
               report($sformatf("qz: got %h want %h", rsp_word.qz, want.qz));
            if (rsp_word.region !== want.region)
               report($sformatf("region: got %0d want %0d", rsp_word.region, want.region));
         end
      end
   end

   initial begin
      row_type rows[$];
      int idle_pct[4];
      idle_pct = '{0, 83, 0, 11};
      rows.push_back('{make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                       '{32'sd0, 32'sd0, 32'sd0, REG_A}});
      rows.push_back('{make_word(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                                 MAXC, MAXC, MAXC), 1, '{MAXC, MAXC, MAXC, REG_A}});
      rows.push_back('{make_word(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC,
                                 MINC, MINC, MINC), 1, '{MINC, MINC, MINC, REG_A}});
      rows.push_back('{make_word(0, 0, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0), 1,
                       '{32'sd0, 32'sd0, 32'sd0, REG_A}});
      rows.push_back('{make_word(5*ONE, -ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0), 1,
                       '{4*ONE, 32'sd0, 32'sd0, REG_B}});
      rows.push_back('{make_word(-ONE, 5*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0), 1,
                       '{32'sd0, 4*ONE, 32'sd0, REG_C}});
      rows.push_back('{make_word(2*ONE, -ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0), 0, 'x});
      rows.push_back('{make_word(-ONE, 2*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0), 0, 'x});
      rows.push_back('{make_word(3*ONE, 3*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0), 0, 'x});
      rows.push_back('{make_word(ONE, ONE, 5*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0), 0, 'x});
      rows.push_back('{make_word(3, 7, -5, 0, 0, 0, 3*ONE, ONE, 7, ONE, 3*ONE, -9), 0, 'x});
      rows.push_back('{make_word(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0), 0, 'x});
      rows.push_back('{make_word(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, 0, 0), 0, 'x});
      rows.push_back('{make_word(ONE, ONE, ONE, ONE, 0, 0, ONE, 0, 0, ONE, 0, 0), 1,
                       '{ONE, 32'sd0, 32'sd0, REG_A}});
      rows.push_back('{make_word(0, MAXC, 0, MINC, MINC, MINC, MAXC, MAXC, MAXC,
                                 MAXC, MINC, 0), 0, 'x});
      rows.push_back('{make_word(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC,
                                 MINC, MINC, MINC), 0, 'x});
      rows.push_back('{make_word(MINC, MAXC, 0, MAXC, MINC, 0, MINC, MINC, 0,
                                 MAXC, MAXC, 0), 0, 'x});
      rows.push_back('{make_word(-1, -1, -1, 1, 1, 1, -1, 1, 1, 1, -1, 1), 0, 'x});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         if (rows[i].known) begin
            rsp_type got;
            got = closest_point(rows[i].word);
            if (got !== rows[i].result)
               report($sformatf("directed row %0d: predictor %h table %h",
                                i, got, rows[i].result));
         end
         send(rows[i].word);
      end
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle = idle_pct[ph];
         repeat (410) send(rand_word());
         start <= 1'b0;
         @(posedge clock);
         sender_idle = 0;
         repeat ($urandom_range(30)) @(posedge clock);
      end
      start <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
